/* hw/rtl/bcs_pkg.sv */
// shared types and constants for the batch cosine similarity block
package bcs_pkg;

    localparam int ELEM_W = 16;
    localparam int LEN_W  = 11;
    localparam int QE_W   = 42;
    localparam int DOT_W  = 43;
    localparam int IDX_W  = 16;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    localparam logic OP_QUERY = 1'b0;
    localparam logic OP_CAND  = 1'b1;

    // job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [QE_W-1:0]         qe;
        logic [QE_W-1:0]         ce;
        logic [IDX_W-1:0]        idx;
        logic                    last;
    } bcs_job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MULP,
        B_MULD,
        B_ROOT,
        B_OUT
    } bcs_back_state_t;

endpackage

/* hw/rtl/batch_cosine_similarity.sv */
// top level of the batch cosine similarity scorer
// usage:
//   input channel in_valid/in_ready carries one element word per accept:
//   operation 0 loads a query element, 1 streams a candidate element.
//   vector_length is written through cfg_we while the block is idle.
//   after the last element of each candidate one word leaves on
//   out_valid/out_ready: score in q1.15, candidate_index, last_score.
// throughput: one element word per cycle while the job queue has room.
// from the final candidate element to its score, the serial products and
//   the bitwise root search in the back end set the delay, so short
//   vectors back up the queue and in_ready drops until a job leaves.
// reset clears the length to 1024, the position, energies and the
//   candidate counter; query memory is undefined until written.
// when the receiver stalls, the score word holds in the output register
//   and the front keeps taking elements until the queue fills.
module batch_cosine_similarity #(
    parameter int MAX_DIM = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic signed [15:0] element,
    input  logic               batch_end,
    input  logic               cfg_we,
    input  logic [10:0]        vector_length,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] score,
    output logic [15:0]        candidate_index,
    output logic               last_score
);
    import bcs_pkg::*;

    logic              q_push, q_pop, q_not_empty;
    logic [QCNT_W-1:0] q_level;
    bcs_job_t          q_in, q_head;

    bcs_front #(.MAX_DIM(MAX_DIM)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .element       (element),
        .batch_end     (batch_end),
        .cfg_we        (cfg_we),
        .vector_length (vector_length),
        .q_level       (q_level),
        .push          (q_push),
        .job           (q_in)
    );

    bcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .level     (q_level)
    );

    bcs_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .not_empty       (q_not_empty),
        .head            (q_head),
        .pop             (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .score           (score),
        .candidate_index (candidate_index),
        .last_score      (last_score)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && !q_pop && (q_level == QCNT_W'(QDEPTH))))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_level != '0)
        else $error("job queue underflow");

    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_level >= QCNT_W'(QDEPTH - 1))
        else $error("input stalled with queue room");
`endif
endmodule

/* hw/rtl/bcs_ram.sv */
// generic single-port ram with registered read
module bcs_ram #(
    parameter int W = 16,
    parameter int D = 1024,
    parameter int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [W-1:0]  wdata,
    output logic [W-1:0]  rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* hw/rtl/bcs_front.sv */
// front end: accepts elements, holds the query, accumulates dot and energies
module bcs_front #(
    parameter int MAX_DIM = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        operation,
    input  logic signed [15:0]          element,
    input  logic                        batch_end,
    input  logic                        cfg_we,
    input  logic [bcs_pkg::LEN_W-1:0]   vector_length,
    input  logic [bcs_pkg::QCNT_W-1:0]  q_level,
    output logic                        push,
    output bcs_pkg::bcs_job_t           job
);
    import bcs_pkg::*;

    localparam int PW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = ((PW > LEN_W) ? PW : LEN_W) + 1;
    localparam logic [LEN_W-1:0] MAX_LEN =
        (MAX_DIM > 2047) ? 11'd2047 : LEN_W'(MAX_DIM);

    logic [LEN_W-1:0] len_reg;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [LEN_W-1:0] len_eff;
    logic             accept, last;

    logic             s1_valid_reg, s1_op_reg, s1_be_reg, s1_first_reg, s1_last_reg;
    logic signed [ELEM_W-1:0] s1_elem_reg;
    logic signed [ELEM_W-1:0] q_data;

    logic [QE_W-1:0]         qe_reg, qe_next, ce_reg, ce_next;
    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [IDX_W-1:0]        cnt_reg, cnt_next;
    logic signed [31:0]      prod, sq_s;

    assign accept = in_valid && in_ready;
    // an item in flight may still push, so keep one slot spare for it
    assign in_ready = (q_level < QCNT_W'(QDEPTH - 1)) ||
                      ((q_level == QCNT_W'(QDEPTH - 1)) && !s1_valid_reg);

    always_comb
    begin
        if (len_reg == '0)
            len_eff = 11'd1;
        else if (len_reg > MAX_LEN)
            len_eff = MAX_LEN;
        else
            len_eff = len_reg;
    end

    assign last     = (CW'(pos_reg) + CW'(1)) >= CW'(len_eff);
    assign pos_next = last ? '0 : pos_reg + PW'(1);

    bcs_ram #(.W(ELEM_W), .D(MAX_DIM), .AW(PW)) u_query (
        .clk   (clk),
        .we    (accept && (operation == OP_QUERY)),
        .addr  (pos_reg),
        .wdata (element),
        .rdata (q_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= LEN_RESET;
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
            qe_reg       <= '0;
            ce_reg       <= '0;
            dot_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                len_reg <= vector_length;
            if (accept)
                pos_reg <= pos_next;
            s1_valid_reg <= accept;
            qe_reg       <= qe_next;
            ce_reg       <= ce_next;
            dot_reg      <= dot_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= operation;
            s1_elem_reg  <= element;
            s1_be_reg    <= batch_end;
            s1_first_reg <= (pos_reg == '0);
            s1_last_reg  <= last;
        end
    end

    assign prod = q_data * s1_elem_reg;
    assign sq_s = s1_elem_reg * s1_elem_reg;

    always_comb
    begin
        qe_next  = qe_reg;
        ce_next  = ce_reg;
        dot_next = dot_reg;
        cnt_next = cnt_reg;
        push     = 1'b0;
        job.dot  = dot_reg;
        job.qe   = qe_reg;
        job.ce   = ce_reg;
        job.idx  = cnt_reg;
        job.last = s1_be_reg;
        if (s1_valid_reg)
        begin
            if (s1_op_reg == OP_QUERY)
            begin
                qe_next = (s1_first_reg ? '0 : qe_reg) + QE_W'(unsigned'(sq_s));
            end
            else
            begin
                dot_next = (s1_first_reg ? '0 : dot_reg) + DOT_W'(prod);
                ce_next  = (s1_first_reg ? '0 : ce_reg) + QE_W'(unsigned'(sq_s));
                job.dot  = dot_next;
                job.ce   = ce_next;
                if (s1_last_reg)
                begin
                    push     = 1'b1;
                    cnt_next = s1_be_reg ? '0 : cnt_reg + IDX_W'(1);
                    // a scored candidate leaves the accumulators clear
                    dot_next = '0;
                    ce_next  = '0;
                end
            end
        end
    end
endmodule

/* hw/rtl/bcs_queue.sv */
// short job queue between front and back
module bcs_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  bcs_pkg::bcs_job_t           push_job,
    input  logic                        pop,
    output bcs_pkg::bcs_job_t           head,
    output logic                        not_empty,
    output logic [bcs_pkg::QCNT_W-1:0]  level
);
    import bcs_pkg::*;

    bcs_job_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [QCNT_W-1:0] level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + QPTR_W'(1);
            if (pop)
                rd_reg <= rd_reg + QPTR_W'(1);
            level_reg <= level_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_reg] <= push_job;
    end

    assign head      = entry_reg[rd_reg];
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;
endmodule

/* hw/rtl/bcs_back.sv */
// back end: serial energy and dot products, bitwise root search, output register
module bcs_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   not_empty,
    input  bcs_pkg::bcs_job_t      head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [15:0]     score,
    output logic [15:0]            candidate_index,
    output logic                   last_score
);
    import bcs_pkg::*;

    localparam int MA_W = 86;
    localparam int MB_W = 43;
    localparam int P_W  = 84;
    localparam int R_W  = 120;
    localparam logic [5:0] MUL_LAST = 6'd42;

    bcs_back_state_t state_reg, state_next;
    bcs_job_t        job_reg, job_next;
    logic [MA_W-1:0] a_reg, a_next, acc_reg, acc_next, acc_step;
    logic [MB_W-1:0] b_reg, b_next, mag;
    logic [P_W-1:0]  p_reg, p_next;
    logic [R_W-1:0]  s_reg, s_next, x_reg, x_next, pk_reg, pk_next, cand, t_val;
    logic [15:0]     m_reg, m_next;
    logic [3:0]      k_reg, k_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        p_reg   <= p_next;
        s_reg   <= s_next;
        x_reg   <= x_next;
        pk_reg  <= pk_next;
        m_reg   <= m_next;
        k_reg   <= k_next;
        cnt_reg <= cnt_next;
    end

    assign mag      = job_reg.dot[DOT_W-1] ? MB_W'(-job_reg.dot) : MB_W'(job_reg.dot);
    assign acc_step = acc_reg + (b_reg[0] ? a_reg : '0);
    // x holds m*p shifted by k+1, pk holds p shifted by 2k
    assign cand     = s_reg + x_reg + pk_reg;
    assign t_val    = R_W'({acc_reg, 30'b0});
    assign fits     = (cand <= t_val);

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        s_next     = s_reg;
        x_next     = x_reg;
        pk_next    = pk_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        pop        = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (not_empty)
                begin
                    pop      = 1'b1;
                    job_next = head;
                    a_next   = MA_W'(head.qe);
                    b_next   = MB_W'(head.ce);
                    acc_next = '0;
                    cnt_next = '0;
                    m_next   = '0;
                    if ((head.qe == '0) || (head.ce == '0))
                        state_next = B_OUT;
                    else
                        state_next = B_MULP;
                end
            end
            B_MULP:
            begin
                acc_next = acc_step;
                a_next   = a_reg << 1;
                b_next   = b_reg >> 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    p_next     = P_W'(acc_step);
                    a_next     = MA_W'(mag);
                    b_next     = mag;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = B_MULD;
                end
            end
            B_MULD:
            begin
                acc_next = acc_step;
                a_next   = a_reg << 1;
                b_next   = b_reg >> 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == MUL_LAST)
                begin
                    s_next     = '0;
                    x_next     = '0;
                    pk_next    = R_W'({p_reg, 30'b0});
                    k_next     = 4'd15;
                    state_next = B_ROOT;
                end
            end
            B_ROOT:
            begin
                pk_next = pk_reg >> 2;
                x_next  = x_reg >> 1;
                if (fits)
                begin
                    s_next        = cand;
                    x_next        = (x_reg >> 1) + pk_reg;
                    m_next[k_reg] = 1'b1;
                end
                k_next = k_reg - 4'd1;
                // full scale reached on the top bit: nothing more can fit
                if ((k_reg == 4'd0) || ((k_reg == 4'd15) && fits))
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign score = job_reg.dot[DOT_W-1] ? -signed'(m_reg) :
                   (m_reg[15] ? 16'sd32767 : signed'(m_reg));
    assign candidate_index = job_reg.idx;
    assign last_score      = job_reg.last;
endmodule

/* verif/bcs_score_checker.sv */
// score predictor and checker for the batch cosine similarity block
module bcs_score_checker #(
    parameter int MAX_DIM = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               operation,
    input  logic signed [bcs_pkg::ELEM_W-1:0]  element,
    input  logic                               batch_end,
    input  logic                               cfg_we,
    input  logic [bcs_pkg::LEN_W-1:0]          vector_length,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic signed [bcs_pkg::ELEM_W-1:0]  score,
    input  logic [bcs_pkg::IDX_W-1:0]          candidate_index,
    input  logic                               last_score,
    output int                                 fail_count,
    output int                                 pending,
    output int                                 scores_seen
);
    import bcs_pkg::*;

    typedef struct {
        logic signed [ELEM_W-1:0] score;
        logic [IDX_W-1:0]         idx;
        logic                     last;
    } score_word_t;

    score_word_t               score_q[$];
    logic signed [ELEM_W-1:0]  query_mem[MAX_DIM];
    logic [LEN_W-1:0]          len_reg;
    longint                    q_energy;
    longint                    c_energy;
    longint                    dot_acc;
    int                        elem_pos;
    logic [IDX_W-1:0]          cand_count;

    // exact dot / sqrt(qe*ce) in q1.15, magnitude truncated, found by bisection
    function automatic logic signed [ELEM_W-1:0] cosine_q15(longint dot, longint qe,
                                                            longint ce);
        bit [127:0]      prod;
        bit [127:0]      rhs;
        bit [127:0]      t;
        longint unsigned mag;
        int              lo;
        int              hi;
        int              mid;
        if (qe == 0 || ce == 0)
            return '0;
        mag  = (dot < 0) ? -dot : dot;
        prod = 128'(qe) * 128'(ce);
        rhs  = (128'(mag) * 128'(mag)) << 30;
        lo   = 0;
        hi   = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            t   = prod * 128'(mid * mid);
            if (t <= rhs)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (dot < 0)
            return ELEM_W'(-lo);
        return (lo > 32767) ? ELEM_W'(32767) : ELEM_W'(lo);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int          n;
        int          pos;
        int          idx;
        longint      sq;
        bit          at_end;
        score_word_t w;
        score_word_t got;
        if (!rst_n)
        begin
            score_q.delete();
            len_reg     = LEN_RESET;
            q_energy    = 0;
            c_energy    = 0;
            dot_acc     = 0;
            elem_pos    = 0;
            cand_count  = '0;
            fail_count  = 0;
            pending     = 0;
            scores_seen = 0;
        end
        else
        begin
            if (cfg_we)
                len_reg = vector_length;
            if (in_valid && in_ready)
            begin
                n = len_reg;
                if (n == 0)
                    n = 1;
                if (n > MAX_DIM)
                    n = MAX_DIM;
                pos      = elem_pos;
                idx      = pos % MAX_DIM;
                sq       = longint'(element) * longint'(element);
                at_end   = (pos + 1 >= n);
                elem_pos = at_end ? 0 : pos + 1;
                if (operation == OP_QUERY)
                begin
                    query_mem[idx] = element;
                    q_energy = ((pos == 0) ? 0 : q_energy) + sq;
                end
                else
                begin
                    dot_acc  = ((pos == 0) ? 0 : dot_acc)
                               + longint'(query_mem[idx]) * longint'(element);
                    c_energy = ((pos == 0) ? 0 : c_energy) + sq;
                    if (at_end)
                    begin
                        w.score = cosine_q15(dot_acc, q_energy, c_energy);
                        w.idx   = cand_count;
                        w.last  = batch_end;
                        score_q.push_back(w);
                        cand_count = batch_end ? '0 : cand_count + 1'b1;
                        dot_acc  = 0;
                        c_energy = 0;
                    end
                end
            end
            if (out_valid && out_ready)
            begin
                scores_seen++;
                if (score_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected score word: score %0d index %0d last %0b",
                             $time, score, candidate_index, last_score);
                end
                else
                begin
                    got = score_q.pop_front();
                    if (score !== got.score)
                    begin
                        fail_count++;
                        $display("%0t: score mismatch: expected %0d actual %0d",
                                 $time, got.score, score);
                    end
                    if (candidate_index !== got.idx)
                    begin
                        fail_count++;
                        $display("%0t: candidate_index mismatch: expected %0d actual %0d",
                                 $time, got.idx, candidate_index);
                    end
                    if (last_score !== got.last)
                    begin
                        fail_count++;
                        $display("%0t: last_score mismatch: expected %0b actual %0b",
                                 $time, got.last, last_score);
                    end
                end
            end
            pending = score_q.size();
        end
    end

endmodule

/* verif/batch_cosine_similarity_tb.sv */
// stimulus and verdict for the batch cosine similarity block
module batch_cosine_similarity_tb;
    import bcs_pkg::*;

    localparam int MAX_DIM   = 1024;
    localparam int DRAIN_CYC = 150;
    localparam int LIMIT     = 3000000;
    localparam int RAND_ITEMS = 850;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      operation = OP_QUERY;
    logic signed [ELEM_W-1:0]  element = '0;
    logic                      batch_end = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [LEN_W-1:0]          vector_length = LEN_RESET;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [ELEM_W-1:0]  score;
    logic [IDX_W-1:0]          candidate_index;
    logic                      last_score;

    int fail_count;
    int pending;
    int scores_seen;

    // sender-side view of the block, used to keep candidates on loaded entries
    int                        cur_len = 1024;
    int                        pos = 0;
    bit                        loaded[MAX_DIM];
    bit signed [ELEM_W-1:0]    qval[MAX_DIM];
    int                        words_sent = 0;
    bit                        no_idle = 1'b0;
    bit                        hold_rx = 1'b0;
    int                        cycles = 0;

    batch_cosine_similarity #(.MAX_DIM(MAX_DIM)) DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .element(element), .batch_end(batch_end),
        .cfg_we(cfg_we), .vector_length(vector_length),
        .out_valid(out_valid), .out_ready(out_ready),
        .score(score), .candidate_index(candidate_index), .last_score(last_score)
    );

    bcs_score_checker #(.MAX_DIM(MAX_DIM)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .element(element), .batch_end(batch_end),
        .cfg_we(cfg_we), .vector_length(vector_length),
        .out_valid(out_valid), .out_ready(out_ready),
        .score(score), .candidate_index(candidate_index), .last_score(last_score),
        .fail_count(fail_count), .pending(pending), .scores_seen(scores_seen)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver: random ready bursts, one long hold on request
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_rx)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_rx = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    task automatic send_word(logic op, logic signed [ELEM_W-1:0] el, logic be);
        int idx;
        idx = pos % MAX_DIM;
        // a candidate word may only meet a query entry that was written
        if (op == OP_CAND && !loaded[idx])
            op = OP_QUERY;
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        element   <= el;
        batch_end <= be;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (op == OP_QUERY)
        begin
            loaded[idx] = 1'b1;
            qval[idx]   = el;
        end
        pos = (pos + 1 >= cur_len) ? 0 : pos + 1;
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic set_length(logic [LEN_W-1:0] v);
        drain();
        cfg_we        <= 1'b1;
        vector_length <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_len = (v == 0) ? 1 : ((v > MAX_DIM) ? MAX_DIM : int'(v));
    endtask

    function automatic logic signed [ELEM_W-1:0] pick_value(int kind, int idx);
        int v;
        case (kind)
            0: return ELEM_W'($urandom);
            1: return qval[idx];
            2: return (qval[idx] == -32768) ? 16'sd32767 : -qval[idx];
            3: return '0;
            4: return ELEM_W'($urandom_range(0, 15)) - 16'sd8;
            5:
            begin
                v = int'(qval[idx]) + int'($urandom_range(0, 255)) - 128;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                return ELEM_W'(v);
            end
            6: return ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
            default: return '0;
        endcase
    endfunction

    // query words from the current position up to the end of the vector
    task automatic load_query(int kind);
        do
        begin
            send_word(OP_QUERY, pick_value(kind, pos), 1'b0);
        end
        while (pos != 0);
    endtask

    // candidate words to the end of the vector; stray batch_end on early words
    task automatic send_candidate(int kind, bit end_batch);
        bit fin;
        do
        begin
            fin = (pos + 1 >= cur_len);
            send_word(OP_CAND, pick_value(kind, pos % MAX_DIM),
                      fin ? end_batch : ($urandom_range(0, 7) == 0));
        end
        while (pos != 0);
    endtask

    initial
    begin
        int n_cand;
        int rnd_start;
        int lens[8];
        bit held;
        lens = '{1, 2, 3, 5, 8, 0, 13, 16};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset length and the out-of-range top value, cut short before the end
        send_word(OP_QUERY, 16'sd300, 1'b0);
        send_word(OP_QUERY, -16'sd300, 1'b0);
        send_word(OP_QUERY, 16'sh7fff, 1'b0);
        set_length(11'd2047);
        send_word(OP_QUERY, 16'sh8000, 1'b0);
        set_length(11'd3);
        // position already past the new last one, so this word ends the vector
        send_word(OP_QUERY, 16'sd5, 1'b0);
        send_candidate(1, 1'b0);

        set_length(11'd4);
        send_word(OP_QUERY, 16'sh8000, 1'b0);
        send_word(OP_QUERY, 16'sh7fff, 1'b0);
        send_word(OP_QUERY, 16'sd0, 1'b0);
        send_word(OP_QUERY, 16'sd1, 1'b1);
        send_candidate(1, 1'b0);
        send_candidate(3, 1'b0);
        send_candidate(2, 1'b1);
        send_candidate(0, 1'b0);
        // all-zero query
        load_query(3);
        send_candidate(0, 1'b1);
        // length zero behaves as one
        set_length(11'd0);
        load_query(0);
        send_candidate(0, 1'b0);
        send_candidate(2, 1'b1);
        // query and candidate words mixed in one vector
        set_length(11'd3);
        load_query(0);
        send_word(OP_CAND, 16'sd1000, 1'b0);
        send_word(OP_QUERY, 16'sh8000, 1'b0);
        send_word(OP_CAND, 16'sh7fff, 1'b1);
        // length cut mid-vector ends it early
        set_length(11'd4);
        send_word(OP_CAND, 16'sd77, 1'b0);
        send_word(OP_CAND, 16'sh8000, 1'b0);
        set_length(11'd1);
        send_word(OP_CAND, 16'sd5, 1'b1);

        rnd_start = words_sent;
        held = 1'b0;
        while (words_sent - rnd_start < RAND_ITEMS)
        begin
            if (words_sent - rnd_start > RAND_ITEMS * 4 / 5)
                no_idle = 1'b1;
            if ($urandom_range(0, 9) == 0)
                set_length(11'($urandom_range(0, 2047) % 40));
            else
                set_length(11'(lens[$urandom_range(0, 7)]));
            load_query($urandom_range(0, 6));
            if (!held && words_sent - rnd_start > RAND_ITEMS / 3)
            begin
                held = 1'b1;
                hold_rx = 1'b1;
            end
            n_cand = $urandom_range(1, 12);
            for (int c = 0; c < n_cand; c++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_word(logic'($urandom_range(0, 1)), ELEM_W'($urandom),
                              logic'($urandom_range(0, 1)));
                else
                    send_candidate($urandom_range(0, 6), $urandom_range(0, 3) == 0);
            end
        end
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("sent %0d element words, checked %0d scores over lengths 0 to 2047,",
                 words_sent, scores_seen);
        $display("with zero, extreme, matched and negated vectors and a long output hold");
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/bcs_pkg.sv
hw/rtl/bcs_ram.sv
hw/rtl/bcs_front.sv
hw/rtl/bcs_queue.sv
hw/rtl/bcs_back.sv
hw/rtl/batch_cosine_similarity.sv
verif/bcs_score_checker.sv
verif/batch_cosine_similarity_tb.sv
